// File: sv/apfl_pkg.sv
// Shared types, codes and constants of the address pool free list.
package apfl_pkg;

  // Field widths of the request, response and configuration words.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 12;
  localparam int unsigned POOL_W   = 11;

  // First fresh address and the largest number of fresh addresses.
  localparam logic [ADDR_W-1:0] FRESH_BASE = 32'd2000000200;
  localparam logic [POOL_W-1:0] POOL_MAX   = 11'd1024;

  // Default depth of the ring of released addresses.
  localparam int unsigned DEF_RING_DEPTH = 1024;

  // Request modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_REFILL  = 2'd2
  } mode_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// File: sv/apfl_if.sv
// Handshake interfaces for the request, response and configuration channels.
interface apfl_req_if import apfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] released_address;

  modport source (output valid, mode, released_address, input ready);
  modport sink (input valid, mode, released_address, output ready);
endinterface

interface apfl_rsp_if import apfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   granted_address;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, granted_address, status, free_count, input ready);
  modport sink (input valid, granted_address, status, free_count, output ready);
endinterface

interface apfl_cfg_if import apfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POOL_W-1:0] pool_size;

  modport source (output valid, pool_size, input ready);
  modport sink (input valid, pool_size, output ready);
endinterface

// File: sv/address_pool_free_list.sv
// Top level of the address pool free list allocator.
//
//   channel  | direction | words carried
//   ---------+-----------+------------------------------------------------
//   req_i    | in        | mode, released_address
//   rsp_o    | out       | granted_address, status, free_count
//   cfg_i    | in        | pool_size (always ready, takes effect at refill)
//
// One request word is taken every cycle while the response channel does not stall;
// its response word passes the first stage, alongside the ring RAM read, and then
// the output register. A stalled response holds the output register and, through it,
// the stage before it and the request channel; both resume once the response is taken.
// Reset sets the counters at once; the ring RAM needs no clearing pass,
// since the ring count guards every read.
module address_pool_free_list import apfl_pkg::*; #(
  parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  apfl_req_if.sink  req_i,
  apfl_rsp_if.source rsp_o,
  apfl_cfg_if.sink  cfg_i
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SumW = ((CntW > POOL_W) ? CntW : POOL_W) + 1;

  // Allocator state.
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [POOL_W-1:0] issued_q, issued_d;
  logic [POOL_W-1:0] left_q, left_d;
  logic [POOL_W-1:0] pool_size_q;

  // First stage and output register.
  logic              s1_valid_q;
  logic              s1_ring_q;
  logic [ADDR_W-1:0] s1_grant_q;
  status_e           s1_status_q;
  logic [COUNT_W-1:0] s1_free_q;

  logic              out_valid_q;
  logic [ADDR_W-1:0] out_grant_q;
  status_e           out_status_q;
  logic [COUNT_W-1:0] out_free_q;

  logic              req_fire, s1_adv;
  logic              ram_we, ram_re;
  logic [PtrW-1:0]   ram_addr;
  logic [ADDR_W-1:0] ram_rdata;
  logic              grant_ring;
  logic [ADDR_W-1:0] grant_fresh;
  status_e           status_d;
  logic [SumW-1:0]   free_sum;

  // Handshakes: the first stage moves on whenever the output register frees.
  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Next state of the pool for the accepted request.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    issued_d    = issued_q;
    left_d      = left_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    grant_ring  = 1'b0;
    grant_fresh = '0;
    status_d    = ST_OK;
    case (req_i.mode)
      MODE_ALLOC: begin
        if (left_q != '0) begin
          grant_fresh = FRESH_BASE + ADDR_W'(issued_q);
          issued_d    = issued_q + 1'b1;
          left_d      = left_q - 1'b1;
        end else if (count_q != '0) begin
          ram_re     = req_fire;
          grant_ring = 1'b1;
          head_d     = (head_q == PtrW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
          count_d    = count_q - 1'b1;
        end else begin
          status_d = ST_EMPTY;
        end
      end
      MODE_RELEASE: begin
        if (count_q == CntW'(RING_DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ram_we  = req_fire;
          tail_d  = (tail_q == PtrW'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      MODE_REFILL: begin
        head_d   = '0;
        tail_d   = '0;
        count_d  = '0;
        issued_d = '0;
        left_d   = (pool_size_q > POOL_MAX) ? POOL_MAX : pool_size_q;
      end
      default: begin
      end
    endcase
  end

  assign free_sum = SumW'(left_d) + SumW'(count_d);
  assign ram_addr = (req_i.mode == MODE_RELEASE) ? tail_q : head_q;

  // Ring of released addresses.
  apfl_ram #(
    .Width (ADDR_W),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (req_i.released_address),
    .rdata_o (ram_rdata)
  );

  // Pool state and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      issued_q    <= '0;
      left_q      <= POOL_MAX;
      pool_size_q <= POOL_MAX;
    end else begin
      if (req_fire) begin
        head_q   <= head_d;
        tail_q   <= tail_d;
        count_q  <= count_d;
        issued_q <= issued_d;
        left_q   <= left_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        pool_size_q <= cfg_i.pool_size;
      end
    end
  end

  // Valid bits of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload of the two stages.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_ring_q   <= grant_ring;
      s1_grant_q  <= grant_fresh;
      s1_status_q <= status_d;
      s1_free_q   <= free_sum[COUNT_W-1:0];
    end
    if (s1_valid_q && s1_adv) begin
      out_grant_q  <= s1_ring_q ? ram_rdata : s1_grant_q;
      out_status_q <= s1_status_q;
      out_free_q   <= s1_free_q;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.granted_address = out_grant_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.free_count      = out_free_q;

endmodule

// File: sv/apfl_ram.sv
// Generic single-port RAM with a registered read.
module apfl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // At most one write and one read per cycle, at a single address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/apfl_checker.sv
// Port-level checks of the address pool free list, bound to its top level.
module apfl_checker import apfl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [ADDR_W-1:0]   rsp_granted_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [COUNT_W-1:0]  rsp_free_i
);

  logic [2:0] pending_q;

  // Words accepted whose responses have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(req_valid_i && req_ready_i)
                             - 3'(rsp_valid_i && rsp_ready_i);
    end
  end

  // No response while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_i)
    else $error("response valid during reset");

  // A response only stands for a request that was accepted earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 3'd0)
    else $error("response without an accepted request");

  // An empty pool grants nothing and has nothing free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_EMPTY |-> rsp_granted_i == '0 && rsp_free_i == '0)
    else $error("empty status with a grant or free addresses");

  // A stalled response holds its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_granted_i)
      && $stable(rsp_status_i) && $stable(rsp_free_i))
    else $error("stalled response changed");

endmodule

bind address_pool_free_list apfl_checker u_apfl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_granted_i (rsp_o.granted_address),
  .rsp_status_i  (rsp_o.status),
  .rsp_free_i    (rsp_o.free_count)
);
